// ----- design/lcfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned OUT_LEN_W = 9;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE  = 3'd0,
    CFG_END_BYTE    = 3'd1,
    CFG_OWN_ADDRESS = 3'd2,
    CFG_SOURCE_ID_A = 3'd3,
    CFG_SOURCE_ID_B = 3'd4,
    CFG_SOURCE_ID_C = 3'd5,
    CFG_SOURCE_ID_D = 3'd6
  } cfg_index_t;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd2;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd3;
  localparam logic [BYTE_W-1:0] SUM_SEED       = 8'hFF;

  // Frame error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_DEST     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SOURCE   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CHECKSUM = 3'd4;
  localparam logic [ERR_W-1:0] ERR_BAD_END  = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] own_address;
    logic [BYTE_W-1:0] source_id_a;
    logic [BYTE_W-1:0] source_id_b;
    logic [BYTE_W-1:0] source_id_c;
    logic [BYTE_W-1:0] source_id_d;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/lcfp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- design/lcfp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lcfp_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_good;
  logic [8:0] payload_length;
  logic [7:0] frame_source;
  logic [2:0] error_code;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_good, output payload_length, output frame_source, output error_code,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_good, input payload_length, input frame_source, input error_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/lcfp_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcfp_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [lcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lcfp_pkg::BYTE_W-1:0]        cfg_wdata,
  output lcfp_pkg::cfg_t                          cfg
);
  import lcfp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE:  cfg_nxt.start_byte  = cfg_wdata;
        CFG_END_BYTE:    cfg_nxt.end_byte    = cfg_wdata;
        CFG_OWN_ADDRESS: cfg_nxt.own_address = cfg_wdata;
        CFG_SOURCE_ID_A: cfg_nxt.source_id_a = cfg_wdata;
        CFG_SOURCE_ID_B: cfg_nxt.source_id_b = cfg_wdata;
        CFG_SOURCE_ID_C: cfg_nxt.source_id_c = cfg_wdata;
        CFG_SOURCE_ID_D: cfg_nxt.source_id_d = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_byte:  START_BYTE_RST,
                 end_byte:    END_BYTE_RST,
                 own_address: '0,
                 source_id_a: '0,
                 source_id_b: '0,
                 source_id_c: '0,
                 source_id_d: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/lcfp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcfp_core #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire lcfp_pkg::cfg_t cfg,
  lcfp_in_if.sink          in_ch,
  lcfp_out_if.source       out_ch
);
  import lcfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEST, ST_SRC, ST_COUNT, ST_LEN_HI, ST_LEN_LO, ST_DATA, ST_CHECK, ST_END
  } state_t;

  localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W+1)'(MAX_PAYLOAD);

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic               stop_r, stop_nxt;
  logic [BYTE_W-1:0]  src_r, src_nxt;

  logic               ovalid_r;
  logic               pv_r, pv_nxt;
  logic [BYTE_W-1:0]  pb_r, pb_nxt;
  logic [BYTE_W-1:0]  pi_r, pi_nxt;
  logic               good_r, good_nxt;
  logic [OUT_LEN_W-1:0] plen_r, plen_nxt;
  logic [BYTE_W-1:0]  psrc_r, psrc_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;

  logic               fire;
  logic [BYTE_W-1:0]  b;
  logic [LEN_W-1:0]   len_full;
  logic [LEN_W-1:0]   pos_inc;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign len_full    = {len_r[LEN_W-1:BYTE_W], b};
  assign pos_inc     = pos_r + LEN_W'(1);

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    stop_nxt  = stop_r;
    src_nxt   = src_r;
    pv_nxt    = 1'b0;
    pb_nxt    = '0;
    pi_nxt    = '0;
    good_nxt  = 1'b0;
    plen_nxt  = '0;
    psrc_nxt  = '0;
    err_nxt   = ERR_NONE;
    unique case (state_r)
      ST_DEST: begin
        if (b == cfg.own_address) begin
          state_nxt = ST_SRC;
        end else begin
          err_nxt   = ERR_DEST;
          state_nxt = ST_IDLE;
        end
      end
      ST_SRC: begin
        if (b == cfg.source_id_a || b == cfg.source_id_b ||
            b == cfg.source_id_c || b == cfg.source_id_d) begin
          src_nxt   = b;
          state_nxt = ST_COUNT;
        end else begin
          err_nxt   = ERR_SOURCE;
          state_nxt = ST_IDLE;
        end
      end
      ST_COUNT: begin
        state_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_nxt   = {b, {BYTE_W{1'b0}}};
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        len_nxt = len_full;
        if ({1'b0, len_full} > LEN_LIMIT) begin
          err_nxt   = ERR_TOO_LONG;
          state_nxt = ST_IDLE;
        end else if (len_full == '0) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        pv_nxt = 1'b1;
        pb_nxt = b;
        pi_nxt = pos_r[BYTE_W-1:0];
        // stop summing at the first zero byte
        if (!stop_r) begin
          if (b == '0) begin
            stop_nxt = 1'b1;
          end else begin
            sum_nxt = sum_r + b;
          end
        end
        pos_nxt = pos_inc;
        if (pos_inc == len_r) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (b != sum_r) begin
          err_nxt   = ERR_CHECKSUM;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (b == cfg.end_byte) begin
          good_nxt = 1'b1;
          plen_nxt = len_r[OUT_LEN_W-1:0];
          psrc_nxt = src_r;
        end else begin
          err_nxt = ERR_BAD_END;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        len_nxt   = '0;
        pos_nxt   = '0;
        sum_nxt   = SUM_SEED;
        stop_nxt  = 1'b0;
        src_nxt   = '0;
        state_nxt = (b == cfg.start_byte) ? ST_DEST : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      pos_r    <= '0;
      sum_r    <= SUM_SEED;
      stop_r   <= 1'b0;
      src_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (fire) begin
        state_r  <= state_nxt;
        len_r    <= len_nxt;
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        stop_r   <= stop_nxt;
        src_r    <= src_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pv_r   <= pv_nxt;
      pb_r   <= pb_nxt;
      pi_r   <= pi_nxt;
      good_r <= good_nxt;
      plen_r <= plen_nxt;
      psrc_r <= psrc_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.payload_valid  = pv_r;
  assign out_ch.payload_byte   = pb_r;
  assign out_ch.payload_index  = pi_r;
  assign out_ch.frame_good     = good_r;
  assign out_ch.payload_length = plen_r;
  assign out_ch.frame_source   = psrc_r;
  assign out_ch.error_code     = err_r;

endmodule

`default_nettype wire

// ----- design/length_checksum_frame_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Framed byte-stream receiver.
// in_ch carries one received byte per item (valid/ready). Frames are laid out as
// start byte, destination, source, count, length high, length low, payload,
// checksum and end byte. out_ch returns exactly one result item per input item:
// payload bytes with their index, a good-frame flag with length and source, or
// an error code (wrong destination, bad source, too long, checksum, bad end).
// The result for an item is presented in the cycle after the item is
// accepted, from the output register of the parser core.
// Throughput: one item per cycle while results are taken; the whole frame state update is one pass of
// logic between the accepted byte and the result register.
// Receiver stall: the result register holds its item; in_ch.ready stays high
// while the register is empty or being drained in the same cycle, so input
// only stalls when a result sits untaken.
// Reset (rst_n, synchronous): the parser returns to hunting for the start
// byte, the result register empties, and the configuration registers take
// start byte 2, end byte 3 and zero for address and source ids.
// cfg_we/cfg_index/cfg_wdata write one register per cycle; write only while idle.
module length_checksum_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lcfp_pkg::BYTE_W-1:0]    cfg_wdata,
  lcfp_in_if.sink                             in_ch,
  lcfp_out_if.source                          out_ch
);
  import lcfp_pkg::*;

  cfg_t cfg;

  // Hold configuration registers
  lcfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the frame state and register one result per byte
  lcfp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  // A result is either a payload byte, a frame end, or neither
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.payload_valid && out_ch.frame_good))
    else $error("payload and frame_good in one item");

  // A good frame carries no error code
  a_good_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_good) |-> (out_ch.error_code == ERR_NONE))
    else $error("frame_good with error code");

  // Payload bytes never come with an error
  a_pay_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload_valid) |-> (out_ch.error_code == ERR_NONE))
    else $error("payload byte with error code");

  // Input is ready whenever the result register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_length_checksum_frame_parser.sv -----
`timescale 1ns / 1ps

module tb_length_checksum_frame_parser;
  import lcfp_pkg::*;

  localparam int unsigned FRAME_MAX = 256;
  localparam int unsigned LIMIT_NS = 400_000;
  localparam int unsigned PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 290;
  localparam int unsigned MAX_PRINTED = 40;
  // Index past the last register; writes to it must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // Receive phases of the frame tracker
  typedef enum logic [3:0] {
    PH_HUNT, PH_DST, PH_SRC, PH_CNT, PH_LEN_H, PH_LEN_L, PH_PAYLOAD, PH_CSUM, PH_ETX
  } rx_phase_t;

  // Frame shapes the stimulus can build
  typedef enum int {
    FK_GOOD, FK_BAD_DEST, FK_BAD_SRC, FK_TOO_LONG, FK_BAD_SUM, FK_BAD_END, FK_NOISE
  } frame_kind_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              frame_good;
    logic [8:0]        payload_length;
    logic [BYTE_W-1:0] frame_source;
    logic [ERR_W-1:0]  error_code;
  } frame_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  lcfp_in_if  in_ch ();
  lcfp_out_if out_ch ();

  length_checksum_frame_parser #(
    .MAX_PAYLOAD(FRAME_MAX)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor copy of the registers and the frame tracker
  cfg_t              shadow_cfg;
  rx_phase_t         rx_phase;
  logic [LEN_W-1:0]  len_field;
  logic [LEN_W-1:0]  data_count;
  logic [BYTE_W-1:0] csum;
  logic              csum_frozen;
  logic [BYTE_W-1:0] src_latch;

  // Bytes waiting to be sent, and results owed by the block
  logic [BYTE_W-1:0] pending_bytes[$];
  frame_result_t     frame_results_due[$];

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned mismatches;
  int unsigned frames_good;
  int unsigned payload_seen;
  int unsigned err_seen[6];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          in_taken;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("Timeout: %0d of %0d items accepted, %0d results still owed",
             items_accepted, items_queued, frame_results_due.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return the tracker to the hunt with a fresh frame context
  function automatic void clear_frame();
    len_field   = '0;
    data_count  = '0;
    csum        = SUM_SEED;
    csum_frozen = 1'b0;
    src_latch   = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    case (idx)
      CFG_START_BYTE:  shadow_cfg.start_byte  = val;
      CFG_END_BYTE:    shadow_cfg.end_byte    = val;
      CFG_OWN_ADDRESS: shadow_cfg.own_address = val;
      CFG_SOURCE_ID_A: shadow_cfg.source_id_a = val;
      CFG_SOURCE_ID_B: shadow_cfg.source_id_b = val;
      CFG_SOURCE_ID_C: shadow_cfg.source_id_c = val;
      CFG_SOURCE_ID_D: shadow_cfg.source_id_d = val;
      default: ;
    endcase
  endfunction

  function automatic bit is_known_source(logic [BYTE_W-1:0] b);
    return b == shadow_cfg.source_id_a || b == shadow_cfg.source_id_b ||
           b == shadow_cfg.source_id_c || b == shadow_cfg.source_id_d;
  endfunction

  // Advance the frame tracker by one received byte and build its result
  function automatic frame_result_t parse_rx_byte(logic [BYTE_W-1:0] b);
    frame_result_t r;
    r = '0;
    case (rx_phase)
      PH_DST: begin
        if (b == shadow_cfg.own_address) begin
          rx_phase = PH_SRC;
        end else begin
          r.error_code = ERR_DEST;
          rx_phase = PH_HUNT;
        end
      end
      PH_SRC: begin
        if (is_known_source(b)) begin
          src_latch = b;
          rx_phase = PH_CNT;
        end else begin
          r.error_code = ERR_SOURCE;
          rx_phase = PH_HUNT;
        end
      end
      PH_CNT: rx_phase = PH_LEN_H;
      PH_LEN_H: begin
        len_field = {b, 8'h00};
        rx_phase = PH_LEN_L;
      end
      PH_LEN_L: begin
        len_field = {len_field[15:8], b};
        if (len_field > FRAME_MAX) begin
          r.error_code = ERR_TOO_LONG;
          rx_phase = PH_HUNT;
        end else if (len_field == 0) begin
          rx_phase = PH_CSUM;
        end else begin
          rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = data_count[7:0];
        // The sum behaves like a C string: it stops at the first zero byte
        if (!csum_frozen) begin
          if (b == 8'h00) csum_frozen = 1'b1;
          else csum = csum + b;
        end
        data_count = data_count + 1'b1;
        if (data_count == len_field) rx_phase = PH_CSUM;
      end
      PH_CSUM: begin
        if (b != csum) begin
          r.error_code = ERR_CHECKSUM;
          rx_phase = PH_HUNT;
        end else begin
          rx_phase = PH_ETX;
        end
      end
      PH_ETX: begin
        if (b == shadow_cfg.end_byte) begin
          r.frame_good     = 1'b1;
          r.payload_length = len_field[8:0];
          r.frame_source   = src_latch;
        end else begin
          r.error_code = ERR_BAD_END;
        end
        rx_phase = PH_HUNT;
      end
      default: begin
        clear_frame();
        rx_phase = (b == shadow_cfg.start_byte) ? PH_DST : PH_HUNT;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, backpressure and monitor
  // ---------------------------------------------------------------------------

  // Present bytes on the falling edge; hold an item until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      in_ch.valid <= 1'b1;
    end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_ch.rx_byte <= pending_bytes.pop_front();
      in_ch.valid   <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH at %0t: %s got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Sample both channels on the rising edge; predict on input, compare on output
  always @(posedge clk) begin
    frame_result_t want;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      frame_results_due.push_back(parse_rx_byte(in_ch.rx_byte));
      items_accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_results_due.size() == 0) begin
        report_mismatch("unexpected result, error_code", out_ch.error_code, 0);
      end else begin
        want = frame_results_due.pop_front();
        if (out_ch.payload_valid !== want.payload_valid)
          report_mismatch("payload_valid", out_ch.payload_valid, want.payload_valid);
        if (out_ch.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", out_ch.payload_byte, want.payload_byte);
        if (out_ch.payload_index !== want.payload_index)
          report_mismatch("payload_index", out_ch.payload_index, want.payload_index);
        if (out_ch.frame_good !== want.frame_good)
          report_mismatch("frame_good", out_ch.frame_good, want.frame_good);
        if (out_ch.payload_length !== want.payload_length)
          report_mismatch("payload_length", out_ch.payload_length, want.payload_length);
        if (out_ch.frame_source !== want.frame_source)
          report_mismatch("frame_source", out_ch.frame_source, want.frame_source);
        if (out_ch.error_code !== want.error_code)
          report_mismatch("error_code", out_ch.error_code, want.error_code);
        frames_good  += want.frame_good;
        payload_seen += want.payload_valid;
        if (want.error_code != ERR_NONE && want.error_code <= ERR_BAD_END)
          err_seen[want.error_code]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    items_queued++;
  endtask

  // Hold until every queued item was taken and every result came back
  task automatic wait_drained();
    while (items_accepted != items_queued || frame_results_due.size() != 0)
      @(negedge clk);
  endtask

  // One register write per cycle; the shadow copy follows at the write edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(CFG_START_BYTE, c.start_byte);
    write_reg(CFG_END_BYTE, c.end_byte);
    write_reg(CFG_OWN_ADDRESS, c.own_address);
    write_reg(CFG_SOURCE_ID_A, c.source_id_a);
    write_reg(CFG_SOURCE_ID_B, c.source_id_b);
    write_reg(CFG_SOURCE_ID_C, c.source_id_c);
    write_reg(CFG_SOURCE_ID_D, c.source_id_d);
    // The spare index must not disturb any register
    write_reg(CFG_UNUSED_IDX, 8'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return FK_GOOD;
    if (r < 62) return FK_BAD_DEST;
    if (r < 69) return FK_BAD_SRC;
    if (r < 76) return FK_TOO_LONG;
    if (r < 84) return FK_BAD_SUM;
    if (r < 92) return FK_BAD_END;
    return FK_NOISE;
  endfunction

  // Mostly short payloads; now and then a long one or the full size
  function automatic int unsigned pick_length(frame_kind_t kind);
    int unsigned r;
    r = $urandom_range(99);
    if (kind == FK_TOO_LONG) begin
      if (r < 30) return FRAME_MAX + 1;
      if (r < 45) return 16'hFFFF;
      return $urandom_range(16'hFFFF, FRAME_MAX + 1);
    end
    if (r < 8) return 0;
    if (r == 8) return FRAME_MAX;
    if (r < 13) return $urandom_range(80, 13);
    return $urandom_range(12, 1);
  endfunction

  // Build one frame of the given shape and queue its bytes
  task automatic queue_frame(frame_kind_t kind, int unsigned len);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    bit                stopped;
    int unsigned       r;
    sum = SUM_SEED;
    stopped = 1'b0;
    if (kind == FK_NOISE) begin
      // Line noise between frames, mostly clear of the start byte
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom);
        if ($urandom_range(9) != 0)
          while (b == shadow_cfg.start_byte) b = 8'($urandom);
        push_byte(b);
      end
      return;
    end
    push_byte(shadow_cfg.start_byte);
    if (kind == FK_BAD_DEST) begin
      do b = 8'($urandom); while (b == shadow_cfg.own_address);
      push_byte(b);
      return;
    end
    push_byte(shadow_cfg.own_address);
    if (kind == FK_BAD_SRC) begin
      do b = 8'($urandom); while (is_known_source(b));
      push_byte(b);
      return;
    end
    case ($urandom_range(3))
      0: push_byte(shadow_cfg.source_id_a);
      1: push_byte(shadow_cfg.source_id_b);
      2: push_byte(shadow_cfg.source_id_c);
      default: push_byte(shadow_cfg.source_id_d);
    endcase
    push_byte(8'($urandom));
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    if (kind == FK_TOO_LONG) return;
    // Payload salted with zeros and with the framing bytes themselves
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 5) b = 8'h00;
      else if (r < 10) b = shadow_cfg.start_byte;
      else if (r < 15) b = shadow_cfg.end_byte;
      else b = 8'($urandom);
      if (!stopped) begin
        if (b == 8'h00) stopped = 1'b1;
        else sum = sum + b;
      end
      push_byte(b);
    end
    if (kind == FK_BAD_SUM) begin
      push_byte(sum + 8'($urandom_range(255, 1)));
      return;
    end
    push_byte(sum);
    if (kind == FK_BAD_END) begin
      do b = 8'($urandom); while (b == shadow_cfg.end_byte);
      push_byte(b);
    end else begin
      push_byte(shadow_cfg.end_byte);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_t              settings[PHASES];
    int unsigned       send_pct[PHASES];
    int unsigned       recv_pct[PHASES];
    logic [BYTE_W-1:0] directed[$];
    int unsigned       phase_base;
    frame_kind_t       kind;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_queued   = 0;
    items_accepted = 0;
    mismatches     = 0;
    frames_good    = 0;
    payload_seen   = 0;
    foreach (err_seen[i]) err_seen[i] = 0;

    // Shadow registers start at their reset values
    shadow_cfg = '{START_BYTE_RST, END_BYTE_RST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    rx_phase = PH_HUNT;
    clear_frame();

    // Settings per phase: reset values first, then the extremes, then random
    settings[0] = shadow_cfg;
    settings[1] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F};
    settings[2] = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE, 8'h55, 8'hAA};
    settings[3] = cfg_t'($bits(cfg_t)'({$urandom, $urandom}));
    settings[4] = cfg_t'($bits(cfg_t)'({$urandom, $urandom}));
    // Idling per phase: none, sender only, receiver only, then both
    send_pct = '{0, 55, 0, 36, 36};
    recv_pct = '{0, 0, 55, 36, 36};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes under the reset settings: a stray byte while hunting,
    // a zero-length frame, a wrong destination, an oversize length, and a
    // two-byte payload that carries the start byte, closed by a wrong end byte
    directed = '{8'hFF,
                 8'h02, 8'h00, 8'h00, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h03,
                 8'h02, 8'h01,
                 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
                 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02, 8'h10, 8'h11, 8'h04};
    foreach (directed[i]) push_byte(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // Let the last result leave the output register before reprogramming
        wait_drained();
        repeat (3) @(negedge clk);
        program_regs(settings[p]);
      end
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      phase_base = items_queued;
      // Make sure the index reaches its top value at least once on a full-size frame
      if (p == 1) queue_frame(FK_GOOD, FRAME_MAX);
      while (items_queued - phase_base < PHASE_ITEMS / 2) begin
        kind = pick_kind();
        queue_frame(kind, pick_length(kind));
      end
      // Pause the sender until the block has fully caught up
      wait_drained();
      while (items_queued - phase_base < PHASE_ITEMS) begin
        kind = pick_kind();
        queue_frame(kind, pick_length(kind));
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);

    $display("Sent %0d bytes over %0d register settings: %0d payload bytes, %0d good frames",
             items_accepted, PHASES, payload_seen, frames_good);
    $display("Errors seen: dest %0d, source %0d, length %0d, checksum %0d, end %0d",
             err_seen[ERR_DEST], err_seen[ERR_SOURCE], err_seen[ERR_TOO_LONG],
             err_seen[ERR_CHECKSUM], err_seen[ERR_BAD_END]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
